### src/mpfc_pkg.sv
package mpfc_pkg;

	localparam int MODULUS_BITS_DEF = 62;
	localparam int BASE_BITS        = 32;
	localparam int EXP_BITS         = 31;
	localparam int OPER_BITS        = 64;
	localparam int CNT_BITS         = $clog2(OPER_BITS + 1);
	localparam int CFG_IDX_BITS     = 2;
	localparam int CFG_DATA_BITS    = 32;

	localparam logic [CFG_IDX_BITS-1:0] REG_BASE = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_EXP  = CFG_IDX_BITS'(1);

	localparam logic [BASE_BITS-1:0] BASE_RESET = BASE_BITS'(2);
	localparam logic [EXP_BITS-1:0]  EXP_RESET  = EXP_BITS'(1);

	// request to the modular multiply unit
	typedef struct packed {
		logic                start;
		logic [CNT_BITS-1:0] nbits;
	} mm_req_t;

endpackage

### src/mpfc_mulmod.sv
module mpfc_mulmod #(
	parameter int MODULUS_BITS = mpfc_pkg::MODULUS_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  mpfc_pkg::mm_req_t                      req,
	input  logic [MODULUS_BITS-1:0]                a,
	input  logic [mpfc_pkg::OPER_BITS-1:0]         b,
	input  logic [MODULUS_BITS-1:0]                p,
	output logic                                   done,
	output logic [MODULUS_BITS-1:0]                result
);
	import mpfc_pkg::*;

	localparam int W = MODULUS_BITS;

	logic [W-1:0]         a_q;
	logic [W-1:0]         p_q;
	logic [OPER_BITS-1:0] b_q;
	logic [W-1:0]         acc_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [W-1:0]         dbl;
	logic [W-1:0]         nxt;

	function automatic logic [W-1:0] addm(input logic [W-1:0] x, input logic [W-1:0] y,
		input logic [W-1:0] m);
		logic [W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, m})
			s = s - {1'b0, m};
		return s[W-1:0];
	endfunction

	// MSB-first shift-and-add: acc = 2*acc (+ a)
	assign dbl = addm(acc_q, acc_q, p_q);
	assign nxt = b_q[OPER_BITS-1] ? addm(dbl, a_q, p_q) : dbl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= req.nbits;
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= a;
			p_q   <= p;
			b_q   <= b;
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= nxt;
			b_q   <= b_q << 1;
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

### src/modular_power_factor_check.sv
// Computes r = (k * b^n + 1) mod p or (k * b^n - 1) mod p for each request,
// with b and n taken from the base and exponent registers, and reports r and
// whether it is zero. One request is worked on at a time: busy is high from
// the cycle after start until the result strobe. Each exponent bit costs a
// squaring plus a multiply when the bit is set, and every modular multiply
// runs bit-serially through one shared shift-and-add unit, one operand bit
// per cycle. A zero modulus returns at once with residue 0 and divides 0.
// The result is shown for one cycle with done high and cannot be stalled;
// capture it then. Registers may only be written while busy is low.
module modular_power_factor_check #(
	parameter int MODULUS_BITS = mpfc_pkg::MODULUS_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [MODULUS_BITS-1:0]                modulus,
	input  logic [mpfc_pkg::OPER_BITS-1:0]         multiplier,
	input  logic                                   plus_sign,
	input  logic                                   cfg_we,
	input  logic [mpfc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [mpfc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	output logic                                   done,
	output logic                                   divides,
	output logic [MODULUS_BITS-1:0]                residue
);
	import mpfc_pkg::*;

	localparam int W      = MODULUS_BITS;
	localparam int SH     = OPER_BITS - W;
	localparam int EBIT_W = $clog2(EXP_BITS);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_BRED = 4'd1;
	localparam logic [3:0] ST_SQL  = 4'd2;
	localparam logic [3:0] ST_SQ   = 4'd3;
	localparam logic [3:0] ST_SQD  = 4'd4;
	localparam logic [3:0] ST_MUL  = 4'd5;
	localparam logic [3:0] ST_NEXT = 4'd6;
	localparam logic [3:0] ST_KM   = 4'd7;
	localparam logic [3:0] ST_FIN  = 4'd8;

	logic [3:0]           state_q;
	logic [BASE_BITS-1:0] base_q;
	logic [EXP_BITS-1:0]  exponent_q;
	logic [EBIT_W-1:0]    ebit_q;
	logic [W-1:0]         p_q;
	logic [OPER_BITS-1:0] k_q;
	logic                 plus_q;
	logic [W-1:0]         one_q;
	logic [W-1:0]         x_q;
	logic [W-1:0]         acc_q;
	logic                 done_q;
	logic                 divides_q;
	logic [W-1:0]         residue_q;

	mm_req_t              mm_req;
	logic [W-1:0]         op_a;
	logic [OPER_BITS-1:0] op_b;
	logic [W-1:0]         op_p;
	logic                 mm_done;
	logic [W-1:0]         mm_res;
	logic [W-1:0]         one_in;
	logic [W:0]           sum_one;
	logic [W-1:0]         r_fin;

	// 1 mod p
	assign one_in = {{(W-1){1'b0}}, (modulus != W'(1))};

	always_comb begin
		mm_req = '0;
		op_a   = acc_q;
		op_b   = OPER_BITS'(acc_q) << SH;
		op_p   = p_q;
		case (state_q)
			ST_IDLE: begin
				if (start && modulus != '0) begin
					mm_req.start = 1'b1;
					mm_req.nbits = CNT_BITS'(BASE_BITS);
					op_a         = one_in;
					op_b         = {base_q, {(OPER_BITS-BASE_BITS){1'b0}}};
					op_p         = modulus;
				end
			end
			ST_SQL: begin
				mm_req.start = 1'b1;
				mm_req.nbits = CNT_BITS'(W);
			end
			ST_SQD: begin
				if (exponent_q[ebit_q]) begin
					mm_req.start = 1'b1;
					mm_req.nbits = CNT_BITS'(W);
					op_b         = OPER_BITS'(x_q) << SH;
				end
			end
			ST_NEXT: begin
				if (ebit_q == '0) begin
					mm_req.start = 1'b1;
					mm_req.nbits = CNT_BITS'(OPER_BITS);
					op_b         = k_q;
				end
			end
			default: ;
		endcase
	end

	mpfc_mulmod #(
		.MODULUS_BITS(MODULUS_BITS)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.a      (op_a),
		.b      (op_b),
		.p      (op_p),
		.done   (mm_done),
		.result (mm_res)
	);

	assign sum_one = {1'b0, acc_q} + {1'b0, one_q};
	always_comb begin
		if (plus_q)
			r_fin = (sum_one >= {1'b0, p_q}) ? W'(sum_one - {1'b0, p_q}) : sum_one[W-1:0];
		else
			r_fin = (acc_q == '0) ? p_q - W'(1) : acc_q - W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= BASE_RESET;
			exponent_q <= EXP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE: base_q     <= cfg_data[BASE_BITS-1:0];
				REG_EXP:  exponent_q <= cfg_data[EXP_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			ebit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (modulus == '0)
							done_q <= 1'b1;
						else
							state_q <= ST_BRED;
					end
				end
				ST_BRED: begin
					if (mm_done) begin
						ebit_q  <= EBIT_W'(EXP_BITS - 1);
						state_q <= ST_SQL;
					end
				end
				ST_SQL:  state_q <= ST_SQ;
				ST_SQ:   if (mm_done) state_q <= ST_SQD;
				ST_SQD:  state_q <= exponent_q[ebit_q] ? ST_MUL : ST_NEXT;
				ST_MUL:  if (mm_done) state_q <= ST_NEXT;
				ST_NEXT: begin
					if (ebit_q == '0) begin
						state_q <= ST_KM;
					end else begin
						ebit_q  <= ebit_q - EBIT_W'(1);
						state_q <= ST_SQL;
					end
				end
				ST_KM:   if (mm_done) state_q <= ST_FIN;
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			p_q       <= modulus;
			k_q       <= multiplier;
			plus_q    <= plus_sign;
			one_q     <= one_in;
			residue_q <= '0;
			divides_q <= 1'b0;
		end
		if (state_q == ST_BRED && mm_done) begin
			x_q   <= mm_res;
			acc_q <= one_q;
		end
		if ((state_q == ST_SQ || state_q == ST_MUL || state_q == ST_KM) && mm_done)
			acc_q <= mm_res;
		if (state_q == ST_FIN) begin
			residue_q <= r_fin;
			divides_q <= (r_fin == '0);
		end
	end

	assign busy    = (state_q != ST_IDLE);
	assign done    = done_q;
	assign divides = divides_q;
	assign residue = residue_q;

endmodule
